// ===== hw/rtl/epd_pkg.sv =====
// ----------------------------------------------------------------------------
// epd_pkg
// Shared types and constants for the eager press debouncer.
// ----------------------------------------------------------------------------
package epd_pkg;

    localparam int TIME_W      = 32;
    localparam int MS_CFG_W    = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 72;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE = 8'd0,
        REG_HOLDOFF  = 8'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [MS_CFG_W-1:0] holdoff_ms;
        logic [MS_CFG_W-1:0] debounce_ms;
    } t_cfg;

    // first field in the highest bits
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              raw_level;
    } t_in_item;

    typedef struct packed {
        logic [TIME_W-1:0] last_duration;
        logic [TIME_W-1:0] active_duration;
        logic              release_edge;
        logic              press_edge;
        logic              pressed;
    } t_result;

    localparam int IN_ITEM_W = $bits(t_in_item);
    localparam int RESULT_W  = $bits(t_result);

endpackage

// ===== hw/rtl/epd_cfg.sv =====
// ----------------------------------------------------------------------------
// epd_cfg
// Configuration register file: debounce time and release hold-off window.
// ----------------------------------------------------------------------------
module epd_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [epd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [epd_pkg::MS_CFG_W-1:0]   i_cfg_data,
    output epd_pkg::t_cfg                  o_cfg
);
    import epd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE: n_cfg.debounce_ms = i_cfg_data;
                REG_HOLDOFF:  n_cfg.holdoff_ms  = i_cfg_data;
                default: begin
                    // unknown index, write dropped
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms <= MS_CFG_W'(10);
            r_cfg.holdoff_ms  <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== hw/rtl/epd_core.sv =====
// ----------------------------------------------------------------------------
// epd_core
// Debounce state and single-pass next-state logic for one sample.
// ----------------------------------------------------------------------------
module epd_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  epd_pkg::t_in_item  i_item,
    input  epd_pkg::t_cfg      i_cfg,
    output epd_pkg::t_result   o_result
);
    import epd_pkg::*;

    logic              r_prev_raw;
    logic              r_deb_level;
    logic [TIME_W-1:0] r_change_time;
    logic [TIME_W-1:0] r_press_start;
    logic [TIME_W-1:0] r_press_length;
    logic [TIME_W-1:0] r_release_stamp;

    logic              n_deb_level;
    logic [TIME_W-1:0] n_change_time;
    logic [TIME_W-1:0] n_press_start;
    logic [TIME_W-1:0] n_press_length;
    logic [TIME_W-1:0] n_release_stamp;

    logic [TIME_W-1:0] w_since_release;
    logic [TIME_W-1:0] w_since_change;
    logic              w_blocked;
    logic              w_release_ok;

    always_comb begin
        // a raw change restarts the stability timer for this very sample
        n_change_time = (i_item.raw_level != r_prev_raw) ? i_item.now_ms : r_change_time;

        w_since_release = i_item.now_ms - r_release_stamp;
        w_since_change  = i_item.now_ms - n_change_time;
        // a zero stamp means no release seen yet
        w_blocked    = (r_release_stamp != '0) &&
                       (w_since_release < {{(TIME_W-MS_CFG_W){1'b0}}, i_cfg.holdoff_ms});
        w_release_ok = (w_since_change >= {{(TIME_W-MS_CFG_W){1'b0}}, i_cfg.debounce_ms});

        n_deb_level     = r_deb_level;
        n_press_start   = r_press_start;
        n_press_length  = r_press_length;
        n_release_stamp = r_release_stamp;

        if (i_item.raw_level && !r_deb_level) begin
            if (!w_blocked) begin
                n_deb_level    = 1'b1;
                n_press_start  = i_item.now_ms;
                n_press_length = '0;
            end
        end else if (!i_item.raw_level && r_deb_level) begin
            if (w_release_ok) begin
                n_deb_level     = 1'b0;
                n_press_length  = i_item.now_ms - r_press_start;
                n_release_stamp = i_item.now_ms;
            end
        end

        o_result.pressed         = n_deb_level;
        o_result.press_edge      = n_deb_level && !r_deb_level;
        o_result.release_edge    = !n_deb_level && r_deb_level;
        o_result.active_duration = n_deb_level ? (i_item.now_ms - n_press_start) : '0;
        o_result.last_duration   = n_press_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw      <= 1'b0;
            r_deb_level     <= 1'b0;
            r_change_time   <= '0;
            r_press_start   <= '0;
            r_press_length  <= '0;
            r_release_stamp <= '0;
        end else if (i_step) begin
            r_prev_raw      <= i_item.raw_level;
            r_deb_level     <= n_deb_level;
            r_change_time   <= n_change_time;
            r_press_start   <= n_press_start;
            r_press_length  <= n_press_length;
            r_release_stamp <= n_release_stamp;
        end
    end

endmodule

// ===== hw/rtl/eager_press_debouncer_top.sv =====
// ----------------------------------------------------------------------------
// eager_press_debouncer_top
// Button debouncer: immediate press, timed release, hold-off after release.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one raw button sample plus a millisecond time stamp
//   per transaction. Master stream returns exactly one result per sample:
//   debounced level, press/release edges, running and last press duration.
//   Config channel writes debounce_ms (index 0) and holdoff_ms (index 1);
//   it is always ready, and should be written only while the block is idle.
// Data path: an accepted sample sits in the input register; its result is
//   registered in the result register and shown on the master side.
// Throughput: one sample per cycle while m_axis_tready is high; the state update
//   is one pass of 32-bit subtract/compare operations between the two registers.
// Reset: synchronous active-low; clears all debounce state, both pipeline
//   valid bits, and loads debounce_ms = 10, holdoff_ms = 0.
// Back-pressure: when m_axis_tready is low the result holds, the input
//   register still takes one more sample, after which s_axis_tready drops.
// ----------------------------------------------------------------------------
module eager_press_debouncer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [0] raw_level, [32:1] now_ms, [39:33] zero
    input  logic [epd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] pressed, [1] press_edge, [2] release_edge, [34:3] active_duration,
    // [66:35] last_duration, [71:67] zero
    output logic [epd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [epd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [epd_pkg::MS_CFG_W-1:0]     i_cfg_data
);
    import epd_pkg::*;

    t_cfg     w_cfg;
    t_result  w_result;
    logic     w_out_free;
    logic     w_step;
    logic     w_in_take;

    logic     r_in_vld;
    t_in_item r_in_item;
    logic     r_out_vld;
    t_result  r_out_data;

    epd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    epd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign w_out_free    = !r_out_vld || m_axis_tready;
    assign w_step        = r_in_vld && w_out_free;
    assign s_axis_tready = !r_in_vld || w_out_free;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, r_out_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_vld <= 1'b1;
            end else if (w_step) begin
                r_in_vld <= 1'b0;
            end
            if (w_out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_item <= t_in_item'(s_axis_tdata[IN_ITEM_W-1:0]);
        end
        if (w_step) begin
            r_out_data <= w_result;
        end
    end

endmodule

// ===== hw/rtl/epd_checker.sv =====
// ----------------------------------------------------------------------------
// epd_checker
// Port-level checks for the eager press debouncer, bound to the top level.
// ----------------------------------------------------------------------------
module epd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [epd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [epd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [epd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input logic [epd_pkg::MS_CFG_W-1:0]     i_cfg_data
);
    import epd_pkg::*;

    // nothing can come out of the pipe right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // edges agree with the debounced level
    a_edge_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[1] || m_axis_tdata[0]) &&
                          (!m_axis_tdata[2] || !m_axis_tdata[0]))
        else $error("edge flag disagrees with level");

    // released button reports no running duration
    a_idle_duration: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[34:3] == '0)
        else $error("active duration nonzero while released");

endmodule

bind eager_press_debouncer_top epd_checker u_epd_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the eager press debouncer. Button samples with
// wrapping time stamps go in on the slave stream; every sample is mirrored
// into a software copy of the debounce state, and each result on the master
// stream is compared against the oldest predicted result. Both stream sides
// stall at random, and the debounce and hold-off registers change between
// phases while the block is idle.
// ----------------------------------------------------------------------------

class debounce_scoreboard;
    logic [15:0]      debounce_ms;
    logic [15:0]      holdoff_ms;
    logic             prev_raw;
    logic             deb_level;
    logic [31:0]      change_time;
    logic [31:0]      press_start;
    logic [31:0]      press_length;
    logic [31:0]      release_stamp;
    epd_pkg::t_result expected_q[$];
    int unsigned      mismatch_cnt;

    function new();
        debounce_ms   = 16'd10;
        holdoff_ms    = 16'd0;
        prev_raw      = 1'b0;
        deb_level     = 1'b0;
        change_time   = 32'd0;
        press_start   = 32'd0;
        press_length  = 32'd0;
        release_stamp = 32'd0;
        mismatch_cnt  = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [15:0] data);
        case (idx)
            epd_pkg::REG_DEBOUNCE: debounce_ms = data;
            epd_pkg::REG_HOLDOFF:  holdoff_ms  = data;
            default: ;
        endcase
    endfunction

    // advance the debounce state by one sample and queue the result it gives
    function void note_sample(logic raw, logic [31:0] now);
        logic             was_pressed;
        logic [31:0]      since;
        epd_pkg::t_result r;
        was_pressed = deb_level;
        if (raw != prev_raw) begin
            change_time = now;
        end
        prev_raw = raw;
        if (raw && !deb_level) begin
            since = now - release_stamp;
            // zero stamp means no release seen, so no hold-off
            if (release_stamp == 32'd0 || since >= {16'd0, holdoff_ms}) begin
                deb_level    = 1'b1;
                press_start  = now;
                press_length = 32'd0;
            end
        end else if (!raw && deb_level) begin
            since = now - change_time;
            if (since >= {16'd0, debounce_ms}) begin
                deb_level     = 1'b0;
                press_length  = now - press_start;
                release_stamp = now;
            end
        end
        r.pressed         = deb_level;
        r.press_edge      = deb_level && !was_pressed;
        r.release_edge    = !deb_level && was_pressed;
        r.active_duration = deb_level ? now - press_start : 32'd0;
        r.last_duration   = press_length;
        expected_q.push_back(r);
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void check_result(epd_pkg::t_result got);
        epd_pkg::t_result want;
        if (expected_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
                $display("unexpected result: pressed=%0b press_edge=%0b release_edge=%0b active=%0d last=%0d",
                         got.pressed, got.press_edge, got.release_edge,
                         got.active_duration, got.last_duration);
            end
            return;
        end
        want = expected_q.pop_front();
        if (want !== got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
                $display("result mismatch: expected pressed=%0b press_edge=%0b release_edge=%0b active=%0d last=%0d",
                         want.pressed, want.press_edge, want.release_edge,
                         want.active_duration, want.last_duration);
                $display("                 actual   pressed=%0b press_edge=%0b release_edge=%0b active=%0d last=%0d",
                         got.pressed, got.press_edge, got.release_edge,
                         got.active_duration, got.last_duration);
            end
        end
    endfunction
endclass

module tb;
    import epd_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_IDX  = 8'hFF;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [MS_CFG_W-1:0]    i_cfg_data;

    debounce_scoreboard sb = new();

    logic        calm;
    logic [31:0] cur_time;
    logic        cur_raw;
    int unsigned quiet_cycles;
    int unsigned rx_left;
    logic        rx_on;

    eager_press_debouncer_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            sb.check_result(t_result'(m_axis_tdata[RESULT_W-1:0]));
        end
    end

    // ends the run when no transaction of any kind happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver back-pressure in random bursts
    initial begin
        m_axis_tready = 1'b0;
        rx_left       = 0;
        rx_on         = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_left == 0) begin
                rx_on   = ($urandom_range(0, 3) != 0);
                rx_left = rx_on ? $urandom_range(1, 40) : $urandom_range(1, 18);
            end
            rx_left--;
            m_axis_tready = calm || rx_on;
        end
    end

    task automatic send_sample(input logic raw, input logic [31:0] now);
        t_in_item item;
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        item.raw_level = raw;
        item.now_ms    = now;
        s_axis_tdata   = IN_TDATA_W'(item);
        s_axis_tvalid  = 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_sample(raw, now);
        @(negedge i_clk);
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_CFG_W-1:0] data);
        drain();
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // bouncy button activity over a mostly creeping clock with jumps and wraps
    task automatic run_random(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0:       cur_time = $urandom;
                1:       cur_time = cur_time - $urandom_range(1, 50);
                2:       cur_time = cur_time + $urandom_range(0, 70000);
                3:       cur_time = 32'hFFFF_FFFF - $urandom_range(0, 20);
                default: cur_time = cur_time + $urandom_range(0, 6);
            endcase
            if ($urandom_range(0, 3) == 0) begin
                cur_raw = ~cur_raw;
            end
            send_sample(cur_raw, cur_time);
        end
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        calm          = 1'b0;
        cur_time      = 32'd0;
        cur_raw       = 1'b0;
        quiet_cycles  = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: debounce 10, no hold-off
        send_sample(1'b0, 32'd5);
        send_sample(1'b1, 32'd6);
        send_sample(1'b0, 32'd8);
        send_sample(1'b1, 32'd9);
        send_sample(1'b0, 32'd10);
        send_sample(1'b0, 32'd19);
        send_sample(1'b0, 32'd20);
        send_sample(1'b1, 32'd21);
        send_sample(1'b0, 32'hFFFF_FFF0);
        // release lands on time zero, so the stamp reads as no release
        send_sample(1'b0, 32'd0);

        write_reg(REG_DEBOUNCE, 16'd0);
        write_reg(REG_HOLDOFF, 16'd100);
        send_sample(1'b1, 32'd5);
        send_sample(1'b0, 32'd6);
        send_sample(1'b1, 32'd50);
        send_sample(1'b0, 32'd60);
        send_sample(1'b1, 32'd105);
        send_sample(1'b1, 32'd106);
        send_sample(1'b0, 32'd107);
        // time going backwards wraps far past the window
        send_sample(1'b1, 32'd0);
        send_sample(1'b1, 32'hFFFF_FFFF);
        send_sample(1'b0, 32'hFFFF_FFFF);
        // writes to unknown indexes leave both registers alone
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(REG_TOP_IDX, 16'h5A5A);
        send_sample(1'b1, 32'd150);
        send_sample(1'b0, 32'd151);
        send_sample(1'b1, 32'd200);

        write_reg(REG_DEBOUNCE, 16'd5);
        write_reg(REG_HOLDOFF, 16'd15);
        run_random(220);
        write_reg(REG_DEBOUNCE, 16'hFFFF);
        write_reg(REG_HOLDOFF, 16'hFFFF);
        run_random(200);
        write_reg(REG_DEBOUNCE, 16'd0);
        write_reg(REG_HOLDOFF, 16'd0);
        run_random(200);
        write_reg(REG_DEBOUNCE, 16'($urandom_range(0, 20)));
        write_reg(REG_HOLDOFF, 16'($urandom_range(0, 40)));
        run_random(240);
        write_reg(REG_DEBOUNCE, 16'($urandom_range(0, 20)));
        write_reg(REG_HOLDOFF, 16'($urandom_range(0, 40)));
        run_random(240);
        write_reg(REG_DEBOUNCE, 16'($urandom));
        write_reg(REG_HOLDOFF, 16'($urandom));
        run_random(200);

        // last stretch runs without stalls on either side
        calm = 1'b1;
        write_reg(REG_DEBOUNCE, 16'd3);
        write_reg(REG_HOLDOFF, 16'd8);
        run_random(230);

        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatch_cnt == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
